[src/tse_pkg.sv]
// shared types and constants of the tab-to-space expander
package tse_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned STOP_SLOTS = 16;
  localparam int unsigned STOP_W     = 16;
  localparam int unsigned COL_W      = 16;
  localparam int unsigned STEP_W     = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ONLY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOPS_0_3    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOPS_4_7    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOPS_8_11   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STOPS_12_15  = 3'd5;

  // character codes
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam logic [COL_W-1:0] COL_MAX = 16'hFFFF;

  // what the back end does with a queued byte
  typedef enum logic [1:0] {
    OP_PASS,
    OP_NEWLINE,
    OP_TAB_KEEP,
    OP_TAB_EXPAND
  } op_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       file_start;
    op_t        op;
  } item_t;

  // tab stop settings seen by the back end
  typedef struct packed {
    logic [STEP_W-1:0]                  stop_count;
    logic [STOP_SLOTS-1:0][STOP_W-1:0]  stops;
  } stop_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_UADD,
    ST_SCAN,
    ST_SET,
    ST_DONE
  } state_t;

endpackage

[src/tse_in_if.sv]
// input channel: one text byte per word
interface tse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       file_start;

  modport source (output valid, output in_byte, output file_start, input ready);
  modport sink   (input valid, input in_byte, input file_start, output ready);
endinterface

[src/tse_out_if.sv]
// output channel: a byte and its repeat count per word
interface tse_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [15:0] repeat_count;

  modport source (output valid, output out_byte, output repeat_count, input ready);
  modport sink   (input valid, input out_byte, input repeat_count, output ready);
endinterface

[src/tse_front.sv]
// front end: accepts bytes, tracks the text-seen flag and classifies each byte
module tse_front (
  input  logic          clk,
  input  logic          rst,
  tse_in_if.sink        in_chan,
  input  logic          initial_only,
  input  logic          q_full,
  output logic          push,
  output tse_pkg::item_t entry
);

  logic seen_text;
  logic seen_base;
  logic seen_text_next;

  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && in_chan.ready;
  assign seen_base     = in_chan.file_start ? 1'b0 : seen_text;

  // classify the incoming word
  always_comb begin
    entry.ch         = in_chan.in_byte;
    entry.file_start = in_chan.file_start;
    entry.op         = tse_pkg::OP_PASS;
    seen_text_next   = seen_base;
    if (in_chan.in_byte == tse_pkg::CH_NL) begin
      entry.op       = tse_pkg::OP_NEWLINE;
      seen_text_next = 1'b0;
    end else if (in_chan.in_byte == tse_pkg::CH_TAB) begin
      entry.op = (initial_only && seen_base) ? tse_pkg::OP_TAB_KEEP
                                             : tse_pkg::OP_TAB_EXPAND;
    end else if (in_chan.in_byte != tse_pkg::CH_SP) begin
      seen_text_next = 1'b1;
    end
  end

  // text-seen flag
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_text <= 1'b0;
    end else if (push) begin
      seen_text <= seen_text_next;
    end
  end

endmodule

[src/tse_queue.sv]
// two-entry queue between front and back end
module tse_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tse_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output tse_pkg::item_t head
);

  tse_pkg::item_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[src/tse_back.sv]
// back end: keeps the column, computes tab targets and holds the output word
module tse_back #(
  parameter int unsigned DEFAULT_TAB_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  tse_pkg::stop_cfg_t cfg,
  input  logic              q_valid,
  input  tse_pkg::item_t    q_item,
  output logic              pop,
  tse_out_if.source         out_chan
);

  localparam logic [15:0] DEF_W = 16'(DEFAULT_TAB_WIDTH);

  tse_pkg::state_t state;
  tse_pkg::state_t state_next;

  logic [15:0] column;
  logic [15:0] col_new;
  logic [15:0] col_base;
  logic [4:0]  step;
  logic [15:0] rem;
  logic [15:0] dsh;
  logic [16:0] tgt;
  logic [7:0]  res_byte;
  logic [15:0] res_count;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [15:0] repeat_count;

  logic        load_out;
  logic        uniform;
  logic [15:0] width;
  logic [16:0] rem_sh;
  logic [16:0] rem_diff;
  logic [15:0] rem_new;
  logic [15:0] scan_stop;
  logic        scan_end;
  logic        scan_hit;
  logic [15:0] tclamp;
  logic [15:0] cnt;

  assign out_chan.valid        = out_valid;
  assign out_chan.out_byte     = out_byte;
  assign out_chan.repeat_count = repeat_count;

  // tab stop mode and spacing
  assign uniform = (cfg.stop_count <= 5'd1);
  assign width   = (cfg.stop_count == 5'd0 || cfg.stops[0] == 16'd0) ? DEF_W : cfg.stops[0];
  assign col_base = q_item.file_start ? 16'd0 : column;

  // one restoring division step for the remainder
  assign rem_sh   = {rem, dsh[15]};
  assign rem_diff = rem_sh - {1'b0, width};
  assign rem_new  = rem_diff[16] ? rem_sh[15:0] : rem_diff[15:0];

  // one stop compared per cycle
  assign scan_stop = cfg.stops[step[3:0]];
  assign scan_end  = (step >= cfg.stop_count);
  assign scan_hit  = (scan_stop > column);

  // clamp the target and count the spaces
  assign tclamp = tgt[16] ? tse_pkg::COL_MAX : tgt[15:0];
  assign cnt    = tclamp - column;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tse_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_item.op == tse_pkg::OP_TAB_EXPAND) begin
            state_next = uniform ? tse_pkg::ST_DIV : tse_pkg::ST_SCAN;
          end else begin
            state_next = tse_pkg::ST_DONE;
          end
        end
      end
      tse_pkg::ST_DIV: begin
        if (step == 5'd15) state_next = tse_pkg::ST_UADD;
      end
      tse_pkg::ST_UADD: state_next = tse_pkg::ST_SET;
      tse_pkg::ST_SCAN: begin
        if (scan_end || scan_hit) state_next = tse_pkg::ST_SET;
      end
      tse_pkg::ST_SET:  state_next = tse_pkg::ST_DONE;
      tse_pkg::ST_DONE: begin
        if (load_out) state_next = tse_pkg::ST_IDLE;
      end
      default: state_next = tse_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state)
      tse_pkg::ST_IDLE: pop      = q_valid;
      tse_pkg::ST_DONE: load_out = !out_valid || out_chan.ready;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tse_pkg::ST_IDLE;
      column    <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) column <= col_base;
      if (load_out) column <= col_new;
      if (load_out) out_valid <= 1'b1;
      else if (out_chan.ready) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      tse_pkg::ST_IDLE: begin
        step <= 5'd0;
        rem  <= 16'd0;
        dsh  <= col_base;
        case (q_item.op)
          tse_pkg::OP_NEWLINE: begin
            res_byte <= tse_pkg::CH_NL;
            col_new  <= 16'd0;
          end
          tse_pkg::OP_TAB_KEEP: begin
            res_byte <= tse_pkg::CH_TAB;
            col_new  <= col_base;
          end
          default: begin
            res_byte <= q_item.ch;
            col_new  <= (col_base == tse_pkg::COL_MAX) ? col_base : col_base + 16'd1;
          end
        endcase
        res_count <= 16'd1;
      end
      tse_pkg::ST_DIV: begin
        rem  <= rem_new;
        dsh  <= {dsh[14:0], 1'b0};
        step <= step + 5'd1;
      end
      tse_pkg::ST_UADD: begin
        tgt <= {1'b0, column} + {1'b0, width} - {1'b0, rem};
      end
      tse_pkg::ST_SCAN: begin
        if (scan_end) tgt <= {1'b0, column} + 17'd1;
        else if (scan_hit) tgt <= {1'b0, scan_stop};
        step <= step + 5'd1;
      end
      tse_pkg::ST_SET: begin
        res_byte  <= tse_pkg::CH_SP;
        res_count <= (cnt == 16'd0) ? 16'd1 : cnt;
        col_new   <= (tclamp > column) ? tclamp : column;
      end
      tse_pkg::ST_DONE: begin
        if (load_out) begin
          out_byte     <= res_byte;
          repeat_count <= res_count;
        end
      end
      default: step <= 5'd0;
    endcase
  end

endmodule

[src/tab_to_space_expander_core.sv]
// top level of the tab-to-space expander: configuration registers and wiring
//
// Usage: bytes enter on in_chan (valid/ready), each with file_start, which
// clears the column and text-seen flag before the byte is handled. Every byte
// gives exactly one word on out_chan: the byte (or a space for an expanded
// tab) and a repeat count. Configuration is written through cfg_we,
// cfg_index and cfg_wdata; the user must write it only while the block is
// idle, which the block itself does not enforce; indexes above 5 are ignored.
// A front end accepts and classifies bytes into a two-entry queue, so input is
// taken while the back end works or the output word waits. Newlines, plain
// bytes and kept tabs go from the idle state to the done state; a tab with
// default or single-stop spacing first passes through the 16-step radix-2
// remainder unit, and a tab with a stop list through the one-stop-per-cycle
// scan. The back end pops a new byte only once the last word is loaded.
// Reset clears the column, the flag, the queue, the output valid flag and all
// configuration registers. When the receiver stalls, the output register
// holds its word, the back end waits, and the queue then fills and drops ready.
module tab_to_space_expander_core #(
  parameter int unsigned MAX_STOPS         = 16,
  parameter int unsigned DEFAULT_TAB_WIDTH = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tse_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  tse_in_if.sink                          in_chan,
  tse_out_if.source                       out_chan
);

  logic                initial_only;
  logic [4:0]          stop_count;
  logic [3:0][63:0]    stops_reg;
  tse_pkg::stop_cfg_t  stop_cfg;

  logic                q_full;
  logic                q_valid;
  logic                push;
  logic                pop;
  tse_pkg::item_t      push_item;
  tse_pkg::item_t      head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_only <= 1'b0;
      stop_count   <= 5'd0;
      stops_reg    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tse_pkg::CFG_INITIAL_ONLY: initial_only <= cfg_wdata[0];
        tse_pkg::CFG_STOP_COUNT:   stop_count   <= cfg_wdata[4:0];
        tse_pkg::CFG_STOPS_0_3:    stops_reg[0] <= cfg_wdata;
        tse_pkg::CFG_STOPS_4_7:    stops_reg[1] <= cfg_wdata;
        tse_pkg::CFG_STOPS_8_11:   stops_reg[2] <= cfg_wdata;
        tse_pkg::CFG_STOPS_12_15:  stops_reg[3] <= cfg_wdata;
        default: initial_only <= initial_only;
      endcase
    end
  end

  // stop count limited to the supported number of stops
  assign stop_cfg.stop_count = (stop_count > 5'(MAX_STOPS)) ? 5'(MAX_STOPS) : stop_count;
  assign stop_cfg.stops      = stops_reg;

  tse_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_chan      (in_chan),
    .initial_only (initial_only),
    .q_full       (q_full),
    .push         (push),
    .entry        (push_item)
  );

  tse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  tse_back #(
    .DEFAULT_TAB_WIDTH (DEFAULT_TAB_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (stop_cfg),
    .q_valid  (q_valid),
    .q_item   (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
